@@ rtl/gbre_pkg.sv @@
// Package for the graph reachability engine: command codes, field widths,
// controller states and the control bundle sent from the controller to the cells.
// Has no dependencies.
package gbre_pkg;

    localparam int KIND_W      = 3;
    localparam int NODE_W      = 6;
    localparam int NODES_DEF   = 64;
    localparam int MAX_RESULTS = 64;
    localparam int CNT_W       = 7;
    // Wide enough to compare a node field against any NODES up to 1024
    localparam int EXT_W       = 11;

    localparam logic [KIND_W-1:0] KIND_ADD_NODE   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RM_NODE    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RM_EDGE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CONNECTED  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_COMPONENT  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLR_CLAIMS = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WALK,
        ST_EMIT
    } state_t;

    // Per-cycle commands broadcast along the row of node cells
    typedef struct packed {
        logic add_node;
        logic rm_node;
        logic add_edge;
        logic rm_edge;
        logic walk_start;
        logic walk_step;
        logic claim_walk;
        logic clr_claims;
    } cell_ctl_t;

endpackage

@@ rtl/gbre_cell.sv @@
// One node cell: presence bit, adjacency row, visited and claimed marks.
// Depends on gbre_pkg.
module gbre_cell #(
    parameter int NODES = gbre_pkg::NODES_DEF,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gbre_pkg::cell_ctl_t ctl,
    input  logic [NODES-1:0]    sel_a,
    input  logic [NODES-1:0]    sel_b,
    input  logic [NODES-1:0]    visited_vec,
    output logic                present,
    output logic                visited,
    output logic                claimed,
    output logic                grow
);

    logic             present_reg, present_next;
    logic [NODES-1:0] row_reg, row_next;
    logic             visited_reg, visited_next;
    logic             claimed_reg, claimed_next;
    logic             hit;

    // A visited neighbour pulls this node in, unless a claiming walk finds it already claimed
    assign hit  = |(row_reg & visited_vec);
    assign grow = ctl.walk_step && !visited_reg && hit && !(ctl.claim_walk && claimed_reg);

    // Apply edits, walk starts, walk steps and claim clears
    always_comb
    begin
        present_next = present_reg;
        row_next     = row_reg;
        visited_next = visited_reg;
        claimed_next = claimed_reg;
        if (ctl.add_node && sel_a[IDX])
        begin
            present_next = 1'b1;
        end
        if (ctl.rm_node)
        begin
            if (sel_a[IDX])
            begin
                present_next = 1'b0;
                row_next     = '0;
            end
            else
            begin
                row_next = row_reg & ~sel_a;
            end
        end
        if (ctl.add_edge)
        begin
            if (sel_a[IDX])
            begin
                row_next = row_next | sel_b;
            end
            if (sel_b[IDX])
            begin
                row_next = row_next | sel_a;
            end
        end
        if (ctl.rm_edge)
        begin
            if (sel_a[IDX])
            begin
                row_next = row_next & ~sel_b;
            end
            if (sel_b[IDX])
            begin
                row_next = row_next & ~sel_a;
            end
        end
        if (ctl.walk_start)
        begin
            visited_next = sel_a[IDX];
            if (ctl.claim_walk && sel_a[IDX])
            begin
                claimed_next = 1'b1;
            end
        end
        if (grow)
        begin
            visited_next = 1'b1;
            if (ctl.claim_walk)
            begin
                claimed_next = 1'b1;
            end
        end
        if (ctl.clr_claims)
        begin
            claimed_next = 1'b0;
        end
    end

    // Hold cell state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b0;
            row_reg     <= '0;
            visited_reg <= 1'b0;
            claimed_reg <= 1'b0;
        end
        else
        begin
            present_reg <= present_next;
            row_reg     <= row_next;
            visited_reg <= visited_next;
            claimed_reg <= claimed_next;
        end
    end

    assign present = present_reg;
    assign visited = visited_reg;
    assign claimed = claimed_reg;

endmodule

@@ rtl/graph_bfs_reachability_engine.sv @@
// Top level of the graph reachability engine: controller and the row of node cells.
// Depends on gbre_pkg and gbre_cell.
//
// One command is taken at a time. An edit or claim clear is latched, applied in the
// execute state and its result registered. A walk widens the visited set by one breadth-first level
// per cycle, every node cell testing its adjacency row against the visited set
// in parallel, until no cell grows. A component query then scans the cells one index per
// cycle, holding on a member while the output is occupied, one member transferred
// per cycle when the output is taken.
module graph_bfs_reachability_engine #(
    parameter int NODES = gbre_pkg::NODES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gbre_pkg::KIND_W-1:0] kind,
    input  logic [gbre_pkg::NODE_W-1:0] node_a,
    input  logic [gbre_pkg::NODE_W-1:0] node_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        applied,
    output logic                        reachable,
    output logic [gbre_pkg::NODE_W-1:0] member_node,
    output logic                        member_valid,
    output logic                        last_result
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;

    gbre_pkg::state_t            state_reg, state_next;
    logic [gbre_pkg::KIND_W-1:0] kind_reg;
    logic [gbre_pkg::NODE_W-1:0] a_reg, b_reg;
    logic [IW-1:0]               sc_reg, sc_next;
    logic [gbre_pkg::CNT_W-1:0]  cnt_reg, cnt_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        applied_reg, applied_next;
    logic                        reach_reg, reach_next;
    logic [gbre_pkg::NODE_W-1:0] member_reg, member_next;
    logic                        mvalid_reg, mvalid_next;
    logic                        last_reg, last_next;

    gbre_pkg::cell_ctl_t ctl;
    logic [NODES-1:0]    sel_a, sel_b;
    logic [NODES-1:0]    present_vec, visited_vec, claimed_vec, grow_vec;
    logic [NODES-1:0]    above;
    logic [gbre_pkg::EXT_W-1:0] a_ext, b_ext;
    logic                a_ok, b_ok, pa, pb, out_free, accept;

    assign a_ext = gbre_pkg::EXT_W'(a_reg);
    assign b_ext = gbre_pkg::EXT_W'(b_reg);
    assign a_ok  = a_ext < gbre_pkg::EXT_W'(NODES);
    assign b_ok  = b_ext < gbre_pkg::EXT_W'(NODES);

    // Decode the latched node indexes to one-hot selects
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            sel_a[i] = (a_ext == gbre_pkg::EXT_W'(i));
            sel_b[i] = (b_ext == gbre_pkg::EXT_W'(i));
        end
    end

    assign pa = |(present_vec & sel_a);
    assign pb = |(present_vec & sel_b);

    // Row of node cells
    for (genvar g = 0; g < NODES; g++)
    begin : g_cell
        gbre_cell #(
            .NODES (NODES),
            .IDX   (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .sel_a       (sel_a),
            .sel_b       (sel_b),
            .visited_vec (visited_vec),
            .present     (present_vec[g]),
            .visited     (visited_vec[g]),
            .claimed     (claimed_vec[g]),
            .grow        (grow_vec[g])
        );
    end

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == gbre_pkg::ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign above    = (visited_vec >> sc_reg) >> 1;

    // Next state, cell commands and result
    always_comb
    begin
        state_next     = state_reg;
        sc_next        = sc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        applied_next   = applied_reg;
        reach_next     = reach_reg;
        member_next    = member_reg;
        mvalid_next    = mvalid_reg;
        last_next      = last_reg;
        ctl            = '0;
        ctl.claim_walk = (kind_reg == gbre_pkg::KIND_COMPONENT);

        unique case (state_reg)
            gbre_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = gbre_pkg::ST_EXEC;
                end
            end
            gbre_pkg::ST_EXEC:
            begin
                out_valid_next = 1'b1;
                applied_next   = 1'b0;
                reach_next     = 1'b0;
                member_next    = '0;
                mvalid_next    = 1'b0;
                last_next      = 1'b1;
                state_next     = gbre_pkg::ST_IDLE;
                case (kind_reg)
                    gbre_pkg::KIND_ADD_NODE:
                    begin
                        ctl.add_node = a_ok;
                        applied_next = a_ok;
                    end
                    gbre_pkg::KIND_RM_NODE:
                    begin
                        ctl.rm_node  = a_ok;
                        applied_next = a_ok;
                    end
                    gbre_pkg::KIND_ADD_EDGE:
                    begin
                        ctl.add_edge = pa && pb;
                        applied_next = pa && pb;
                    end
                    gbre_pkg::KIND_RM_EDGE:
                    begin
                        ctl.rm_edge  = pa && pb;
                        applied_next = pa && pb;
                    end
                    gbre_pkg::KIND_CONNECTED:
                    begin
                        if (a_reg == b_reg)
                        begin
                            reach_next = 1'b1;
                        end
                        else if (pa)
                        begin
                            ctl.walk_start = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = gbre_pkg::ST_WALK;
                        end
                    end
                    gbre_pkg::KIND_COMPONENT:
                    begin
                        if (pa)
                        begin
                            ctl.walk_start = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = gbre_pkg::ST_WALK;
                        end
                    end
                    gbre_pkg::KIND_CLR_CLAIMS:
                    begin
                        ctl.clr_claims = 1'b1;
                        applied_next   = 1'b1;
                    end
                    default:
                    begin
                        applied_next = 1'b0;
                    end
                endcase
            end
            gbre_pkg::ST_WALK:
            begin
                // Advance one level; stop once no cell grows
                ctl.walk_step = 1'b1;
                if (grow_vec == '0)
                begin
                    if (kind_reg == gbre_pkg::KIND_COMPONENT)
                    begin
                        sc_next    = '0;
                        cnt_next   = '0;
                        state_next = gbre_pkg::ST_EMIT;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        applied_next   = 1'b0;
                        reach_next     = b_ok && |(visited_vec & sel_b);
                        member_next    = '0;
                        mvalid_next    = 1'b0;
                        last_next      = 1'b1;
                        state_next     = gbre_pkg::ST_IDLE;
                    end
                end
            end
            gbre_pkg::ST_EMIT:
            begin
                // Scan cells in index order; hold while the output is occupied
                if (!visited_vec[sc_reg])
                begin
                    sc_next = sc_reg + 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    applied_next   = 1'b0;
                    reach_next     = 1'b0;
                    member_next    = gbre_pkg::NODE_W'(sc_reg);
                    mvalid_next    = 1'b1;
                    last_next      = (above == '0) ||
                                     (cnt_reg == gbre_pkg::CNT_W'(gbre_pkg::MAX_RESULTS - 1));
                    cnt_next       = cnt_reg + 1'b1;
                    sc_next        = sc_reg + 1'b1;
                    if (last_next)
                    begin
                        state_next = gbre_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = gbre_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbre_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            sc_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sc_reg        <= sc_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Latch the command and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            a_reg    <= node_a;
            b_reg    <= node_b;
        end
        applied_reg <= applied_next;
        reach_reg   <= reach_next;
        member_reg  <= member_next;
        mvalid_reg  <= mvalid_next;
        last_reg    <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign applied      = applied_reg;
    assign reachable    = reach_reg;
    assign member_node  = member_reg;
    assign member_valid = mvalid_reg;
    assign last_result  = last_reg;

`ifndef SYNTHESIS
    a_start_visited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbre_pkg::ST_WALK) |-> |(visited_vec & sel_a))
        else $error("walk start node not visited");
    a_emit_claimed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gbre_pkg::ST_EMIT) |-> ((visited_vec & ~claimed_vec) == '0))
        else $error("component member left unclaimed");
    a_member_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mvalid_reg) |-> (kind_reg == gbre_pkg::KIND_COMPONENT))
        else $error("member emitted outside a component query");
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("command taken while a result is pending");
`endif

endmodule

@@ tb/graph_bfs_reachability_engine_check.sv @@
// Scoreboard for the graph reachability engine: watches both channels, keeps its own
// copy of the graph and claims, predicts every result and compares. Depends on gbre_pkg.
module graph_bfs_reachability_engine_check (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [gbre_pkg::KIND_W-1:0] kind,
    input  logic [gbre_pkg::NODE_W-1:0] node_a,
    input  logic [gbre_pkg::NODE_W-1:0] node_b,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        applied,
    input  logic                        reachable,
    input  logic [gbre_pkg::NODE_W-1:0] member_node,
    input  logic                        member_valid,
    input  logic                        last_result,
    output int                          errors,
    output int                          pending
);

    typedef struct packed {
        logic                        applied;
        logic                        reachable;
        logic [gbre_pkg::NODE_W-1:0] member_node;
        logic                        member_valid;
        logic                        last_result;
    } graph_result_t;

    logic [63:0]   present;
    logic [63:0]   adj [64];
    logic [63:0]   claimed;
    graph_result_t result_q[$];

    function automatic graph_result_t mk(logic ap, logic re,
                                         logic [gbre_pkg::NODE_W-1:0] n,
                                         logic v, logic l);
        graph_result_t r;
        r.applied = ap;
        r.reachable = re;
        r.member_node = n;
        r.member_valid = v;
        r.last_result = l;
        return r;
    endfunction

    // Level-by-level closure; with claims only unclaimed nodes are entered
    function automatic logic [63:0] reach_set(int start, bit use_claims);
        logic [63:0] seen;
        logic [63:0] grow;
        logic [63:0] blocked;
        seen = 64'd1 << start;
        blocked = use_claims ? claimed : 64'd0;
        for (int lvl = 0; lvl < 64; lvl++)
        begin
            grow = seen;
            for (int i = 0; i < 64; i++)
                if (seen[i])
                    grow |= adj[i] & ~blocked;
            seen = grow;
        end
        return seen;
    endfunction

    task automatic predict_command(logic [gbre_pkg::KIND_W-1:0] k, int a, int b);
        logic [63:0]   seen;
        logic          both;
        int            cnt;
        graph_result_t tail_r;
        both = present[a] && present[b];
        case (k)
            gbre_pkg::KIND_ADD_NODE:
            begin
                present[a] = 1'b1;
                result_q.push_back(mk(1'b1, 1'b0, '0, 1'b0, 1'b1));
            end
            gbre_pkg::KIND_RM_NODE:
            begin
                present[a] = 1'b0;
                adj[a] = '0;
                for (int i = 0; i < 64; i++)
                    adj[i][a] = 1'b0;
                result_q.push_back(mk(1'b1, 1'b0, '0, 1'b0, 1'b1));
            end
            gbre_pkg::KIND_ADD_EDGE, gbre_pkg::KIND_RM_EDGE:
            begin
                if (both)
                begin
                    adj[a][b] = (k == gbre_pkg::KIND_ADD_EDGE);
                    adj[b][a] = (k == gbre_pkg::KIND_ADD_EDGE);
                end
                result_q.push_back(mk(both, 1'b0, '0, 1'b0, 1'b1));
            end
            gbre_pkg::KIND_CONNECTED:
            begin
                if (a == b)
                    result_q.push_back(mk(1'b0, 1'b1, '0, 1'b0, 1'b1));
                else if (!present[a])
                    result_q.push_back(mk(1'b0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    seen = reach_set(a, 1'b0);
                    result_q.push_back(mk(1'b0, seen[b], '0, 1'b0, 1'b1));
                end
            end
            gbre_pkg::KIND_COMPONENT:
            begin
                cnt = 0;
                if (present[a])
                begin
                    seen = reach_set(a, 1'b1);
                    claimed |= seen;
                    for (int i = 0; i < 64; i++)
                        if (seen[i])
                        begin
                            result_q.push_back(mk(1'b0, 1'b0, gbre_pkg::NODE_W'(i),
                                                  1'b1, 1'b0));
                            cnt++;
                        end
                end
                if (cnt == 0)
                    result_q.push_back(mk(1'b0, 1'b0, '0, 1'b0, 1'b1));
                else
                begin
                    tail_r = result_q.pop_back();
                    tail_r.last_result = 1'b1;
                    result_q.push_back(tail_r);
                end
            end
            gbre_pkg::KIND_CLR_CLAIMS:
            begin
                claimed = '0;
                result_q.push_back(mk(1'b1, 1'b0, '0, 1'b0, 1'b1));
            end
            default:
                result_q.push_back(mk(1'b0, 1'b0, '0, 1'b0, 1'b1));
        endcase
    endtask

    // Predict on input transfers, compare on output transfers
    always @(posedge clk or negedge rst_n)
    begin
        graph_result_t got;
        graph_result_t want;
        if (!rst_n)
        begin
            present = '0;
            claimed = '0;
            for (int i = 0; i < 64; i++)
                adj[i] = '0;
            result_q.delete();
            errors = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = mk(applied, reachable, member_node, member_valid, last_result);
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: expected ap=%b re=%b node=%0d mv=%b last=%b",
                                     want.applied, want.reachable, want.member_node,
                                     want.member_valid, want.last_result);
                            $display("          got      ap=%b re=%b node=%0d mv=%b last=%b",
                                     got.applied, got.reachable, got.member_node,
                                     got.member_valid, got.last_result);
                        end
                    end
                end
            end
            if (in_valid && in_ready)
                predict_command(kind, int'(node_a), int'(node_b));
        end
        pending = result_q.size();
    end

endmodule

@@ tb/graph_bfs_reachability_engine_test.sv @@
// Testbench top for the graph reachability engine: clock, reset, command stimulus,
// output back-pressure and the verdict. Depends on gbre_pkg, the engine and its checker.
module graph_bfs_reachability_engine_test;

    // Command code that the engine does not use
    localparam logic [gbre_pkg::KIND_W-1:0] KIND_UNUSED = 3'd7;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [gbre_pkg::KIND_W-1:0] kind;
    logic [gbre_pkg::NODE_W-1:0] node_a;
    logic [gbre_pkg::NODE_W-1:0] node_b;
    logic                        out_valid;
    logic                        out_ready;
    logic                        applied;
    logic                        reachable;
    logic [gbre_pkg::NODE_W-1:0] member_node;
    logic                        member_valid;
    logic                        last_result;
    int                          errors;
    int                          pending;
    int                          cycles;
    bit                          calm;
    bit                          hold_off;

    graph_bfs_reachability_engine u_top (.*);

    graph_bfs_reachability_engine_check u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall bursts, one long hold-off, none near the end
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 3);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Give up after a generous cycle count
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("graph_bfs_reachability_engine verification failed");
                $finish;
            end
        end
    end

    // Offer one command and hold it until transferred
    task automatic send_command(logic [gbre_pkg::KIND_W-1:0] k,
                                logic [gbre_pkg::NODE_W-1:0] a,
                                logic [gbre_pkg::NODE_W-1:0] b);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        node_a <= a;
        node_b <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    // Mostly small node indexes so edges land between present nodes
    function automatic logic [gbre_pkg::NODE_W-1:0] pick_node();
        return ($urandom_range(0, 4) == 0) ? gbre_pkg::NODE_W'($urandom_range(0, 63))
                                           : gbre_pkg::NODE_W'($urandom_range(0, 11));
    endfunction

    initial
    begin
        logic [gbre_pkg::KIND_W-1:0] k;
        int                          r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = '0;
        node_a = '0;
        node_b = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: absent ends, self loop, extremes, claims and the unused kind
        send_command(gbre_pkg::KIND_CONNECTED, 6'd5, 6'd5);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd5, 6'd6);
        send_command(gbre_pkg::KIND_COMPONENT, 6'd0, 6'd0);
        send_command(gbre_pkg::KIND_ADD_EDGE, 6'd0, 6'd63);
        send_command(gbre_pkg::KIND_ADD_NODE, 6'd0, 6'd0);
        send_command(gbre_pkg::KIND_ADD_NODE, 6'd63, 6'd63);
        send_command(gbre_pkg::KIND_ADD_NODE, 6'd63, 6'd0);
        send_command(gbre_pkg::KIND_ADD_EDGE, 6'd0, 6'd63);
        send_command(gbre_pkg::KIND_ADD_EDGE, 6'd63, 6'd63);
        send_command(gbre_pkg::KIND_ADD_NODE, 6'd42, 6'd21);
        send_command(gbre_pkg::KIND_ADD_NODE, 6'd21, 6'd42);
        send_command(gbre_pkg::KIND_ADD_EDGE, 6'd21, 6'd63);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd0, 6'd21);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd0, 6'd42);
        send_command(gbre_pkg::KIND_COMPONENT, 6'd63, 6'd0);
        send_command(gbre_pkg::KIND_COMPONENT, 6'd0, 6'd0);
        send_command(gbre_pkg::KIND_CLR_CLAIMS, 6'd0, 6'd0);
        send_command(gbre_pkg::KIND_RM_EDGE, 6'd0, 6'd63);
        send_command(gbre_pkg::KIND_RM_EDGE, 6'd0, 6'd42);
        send_command(gbre_pkg::KIND_COMPONENT, 6'd21, 6'd0);
        send_command(gbre_pkg::KIND_RM_NODE, 6'd63, 6'd0);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd21, 6'd63);
        send_command(KIND_UNUSED, 6'd63, 6'd63);
        send_command(gbre_pkg::KIND_RM_NODE, 6'd0, 6'd0);

        // Chain of 16 nodes, claimed from scratch for a long member list
        send_command(gbre_pkg::KIND_CLR_CLAIMS, 6'd0, 6'd0);
        for (int i = 0; i < 16; i++)
            send_command(gbre_pkg::KIND_ADD_NODE, gbre_pkg::NODE_W'(i), 6'd0);
        for (int i = 0; i < 15; i++)
            send_command(gbre_pkg::KIND_ADD_EDGE, gbre_pkg::NODE_W'(i),
                         gbre_pkg::NODE_W'(i + 1));
        // Stall the output while commands keep coming
        hold_off = 1'b1;
        send_command(gbre_pkg::KIND_COMPONENT, 6'd8, 6'd0);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd0, 6'd15);
        send_command(gbre_pkg::KIND_ADD_EDGE, 6'd5, 6'd40);
        send_command(gbre_pkg::KIND_CONNECTED, 6'd15, 6'd1);
        in_valid <= 1'b0;
        // Pause until the engine has drained
        do @(posedge clk); while (pending != 0);
        repeat (80) @(posedge clk);
        send_command(gbre_pkg::KIND_CLR_CLAIMS, 6'd0, 6'd0);

        // Random: mostly edits and queries over a small node pool
        for (int n = 0; n < 70; n++)
        begin
            if (n == 55)
                calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15)
                k = gbre_pkg::KIND_ADD_NODE;
            else if (r < 22)
                k = gbre_pkg::KIND_RM_NODE;
            else if (r < 45)
                k = gbre_pkg::KIND_ADD_EDGE;
            else if (r < 52)
                k = gbre_pkg::KIND_RM_EDGE;
            else if (r < 72)
                k = gbre_pkg::KIND_CONNECTED;
            else if (r < 90)
                k = gbre_pkg::KIND_COMPONENT;
            else if (r < 97)
                k = gbre_pkg::KIND_CLR_CLAIMS;
            else
                k = KIND_UNUSED;
            send_command(k, pick_node(), pick_node());
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("graph_bfs_reachability_engine verification clean");
        else
            $display("graph_bfs_reachability_engine verification failed");
        $finish;
    end

endmodule
